[design/grma_pkg.sv]
package grma_pkg;

  localparam int unsigned UPC_W      = 6;
  localparam int unsigned A_W        = 34;
  localparam int unsigned B_W        = 17;
  localparam int unsigned P_W        = A_W + B_W;
  localparam int unsigned ACC_W      = 52;
  localparam int unsigned FRAC_M     = 28;
  localparam int unsigned FRAC_F     = 16;
  localparam int unsigned GB_W       = ACC_W - FRAC_M;
  localparam int unsigned SAT_W      = ACC_W - FRAC_F;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = CFG_IDX_W'(1);

  localparam logic [11:0] GRAVITY_RESET = 12'd1256;
  localparam logic [15:0] ALPHA_RESET   = 16'd6898;

  localparam logic [UPC_W-1:0] STEP_WAIT  = UPC_W'(0);
  localparam logic [UPC_W-1:0] STEP_FIRST = UPC_W'(1);
  localparam logic [UPC_W-1:0] STEP_EMIT  = UPC_W'(35);

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_IN_FULL  = 2'd1,
    COND_OUT_FREE = 2'd2
  } cond_e;

  typedef enum logic [1:0] {
    A_Q     = 2'd0,
    A_M     = 2'd1,
    A_ALPHA = 2'd2
  } asel_e;

  typedef enum logic [1:0] {
    B_Q   = 2'd0,
    B_G   = 2'd1,
    B_DLT = 2'd2,
    B_F   = 2'd3
  } bsel_e;

  typedef enum logic [1:0] {
    ACC_NOP  = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } accop_e;

  typedef enum logic [1:0] {
    BIAS_ZERO = 2'd0,
    BIAS_ONE  = 2'd1,
    BIAS_RND  = 2'd2,
    BIAS_FILT = 2'd3
  } bias_e;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_M    = 3'd1,
    WB_GB   = 3'd2,
    WB_F    = 3'd3,
    WB_E    = 3'd4
  } wbop_e;

  typedef struct packed {
    cond_e            cond;
    logic             hold;
    logic [UPC_W-1:0] target;
    logic             emit;
  } sq_t;

  typedef struct packed {
    asel_e       a_sel;
    logic [3:0]  a_idx;
    bsel_e       b_sel;
    logic [1:0]  b_idx;
  } mul_t;

  typedef struct packed {
    accop_e op;
    logic   neg;
    logic   dbl;
    bias_e  bias;
  } acc_t;

  typedef struct packed {
    wbop_e      op;
    logic [3:0] idx;
  } wb_t;

  typedef struct packed {
    sq_t  sq;
    mul_t mul;
    acc_t acc;
    wb_t  wb;
  } ctrl_t;

  typedef struct packed {
    logic in_full;
    logic out_free;
  } seq_stat_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } item_t;

  typedef struct packed {
    logic signed [15:0] earth_accel_x;
    logic signed [15:0] earth_accel_y;
    logic signed [15:0] earth_accel_z;
    logic signed [15:0] body_accel_x;
    logic signed [15:0] body_accel_y;
    logic signed [15:0] body_accel_z;
  } result_t;

  typedef struct packed {
    logic [11:0] gravity;
    logic [15:0] alpha;
  } cfg_t;

  localparam sq_t  SQ_IDLE  = '{cond: COND_NEVER, hold: 1'b0, target: '0, emit: 1'b0};
  localparam mul_t MUL_IDLE = '{a_sel: A_Q, a_idx: 4'd0, b_sel: B_Q, b_idx: 2'd0};
  localparam acc_t ACC_IDLE = '{op: ACC_NOP, neg: 1'b0, dbl: 1'b0, bias: BIAS_ZERO};
  localparam wb_t  WB_IDLE  = '{op: WB_NONE, idx: 4'd0};
  localparam ctrl_t CTRL_IDLE = '{sq: SQ_IDLE, mul: MUL_IDLE, acc: ACC_IDLE, wb: WB_IDLE};

  function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(32767)) begin
      return 16'sh7fff;
    end else if (v < -SAT_W'(32768)) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic mul_t mul_qq(input logic [1:0] a, input logic [1:0] b);
    return '{a_sel: A_Q, a_idx: {2'b00, a}, b_sel: B_Q, b_idx: b};
  endfunction

  function automatic mul_t mul_op(input asel_e as, input logic [3:0] a,
                                  input bsel_e bs, input logic [1:0] b);
    return '{a_sel: as, a_idx: a, b_sel: bs, b_idx: b};
  endfunction

  function automatic acc_t acc_ld(input logic neg, input logic dbl, input bias_e bias);
    return '{op: ACC_LOAD, neg: neg, dbl: dbl, bias: bias};
  endfunction

  function automatic acc_t acc_add(input logic neg, input logic dbl);
    return '{op: ACC_ADD, neg: neg, dbl: dbl, bias: BIAS_ZERO};
  endfunction

  function automatic wb_t wb(input wbop_e op, input logic [3:0] idx);
    return '{op: op, idx: idx};
  endfunction

  // Microprogram. The multiply issued in a step is accumulated in the next
  // step, and the accumulator is written back one step after that.
  // Quaternion index: 0 = w, 1 = x, 2 = y, 3 = z. Matrix index = 3 * row + col.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] step);
    ctrl_t w;
    w = CTRL_IDLE;
    unique case (step)
      6'd0: begin
        w.sq  = '{cond: COND_IN_FULL, hold: 1'b1, target: STEP_FIRST, emit: 1'b0};
        w.mul = mul_qq(2'd2, 2'd2);
      end
      6'd1: begin
        w.mul = mul_qq(2'd3, 2'd3);
        w.acc = acc_ld(1'b1, 1'b1, BIAS_ONE);
      end
      6'd2: begin
        w.mul = mul_qq(2'd1, 2'd2);
        w.acc = acc_add(1'b1, 1'b1);
      end
      6'd3: begin
        w.mul = mul_qq(2'd0, 2'd3);
        w.acc = acc_ld(1'b0, 1'b1, BIAS_ZERO);
        w.wb  = wb(WB_M, 4'd0);
      end
      6'd4: begin
        w.mul = mul_qq(2'd1, 2'd3);
        w.acc = acc_add(1'b1, 1'b1);
      end
      6'd5: begin
        w.mul = mul_qq(2'd0, 2'd2);
        w.acc = acc_ld(1'b0, 1'b1, BIAS_ZERO);
        w.wb  = wb(WB_M, 4'd1);
      end
      6'd6: begin
        w.mul = mul_qq(2'd1, 2'd2);
        w.acc = acc_add(1'b0, 1'b1);
      end
      6'd7: begin
        w.mul = mul_qq(2'd0, 2'd3);
        w.acc = acc_ld(1'b0, 1'b1, BIAS_ZERO);
        w.wb  = wb(WB_M, 4'd2);
      end
      6'd8: begin
        w.mul = mul_qq(2'd1, 2'd1);
        w.acc = acc_add(1'b0, 1'b1);
      end
      6'd9: begin
        w.mul = mul_qq(2'd3, 2'd3);
        w.acc = acc_ld(1'b1, 1'b1, BIAS_ONE);
        w.wb  = wb(WB_M, 4'd3);
      end
      6'd10: begin
        w.mul = mul_qq(2'd2, 2'd3);
        w.acc = acc_add(1'b1, 1'b1);
      end
      6'd11: begin
        w.mul = mul_qq(2'd0, 2'd1);
        w.acc = acc_ld(1'b0, 1'b1, BIAS_ZERO);
        w.wb  = wb(WB_M, 4'd4);
      end
      6'd12: begin
        w.mul = mul_qq(2'd1, 2'd3);
        w.acc = acc_add(1'b1, 1'b1);
      end
      6'd13: begin
        w.mul = mul_qq(2'd0, 2'd2);
        w.acc = acc_ld(1'b0, 1'b1, BIAS_ZERO);
        w.wb  = wb(WB_M, 4'd5);
      end
      6'd14: begin
        w.mul = mul_qq(2'd2, 2'd3);
        w.acc = acc_add(1'b1, 1'b1);
      end
      6'd15: begin
        w.mul = mul_qq(2'd0, 2'd1);
        w.acc = acc_ld(1'b0, 1'b1, BIAS_ZERO);
        w.wb  = wb(WB_M, 4'd6);
      end
      6'd16: begin
        w.mul = mul_qq(2'd1, 2'd1);
        w.acc = acc_add(1'b0, 1'b1);
      end
      6'd17: begin
        w.mul = mul_qq(2'd2, 2'd2);
        w.acc = acc_ld(1'b1, 1'b1, BIAS_ONE);
        w.wb  = wb(WB_M, 4'd7);
      end
      6'd18: begin
        w.mul = mul_op(A_M, 4'd6, B_G, 2'd0);
        w.acc = acc_add(1'b1, 1'b1);
      end
      6'd19: begin
        w.mul = mul_op(A_M, 4'd7, B_G, 2'd0);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_RND);
        w.wb  = wb(WB_M, 4'd8);
      end
      6'd20: begin
        w.mul = mul_op(A_M, 4'd8, B_G, 2'd0);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_RND);
        w.wb  = wb(WB_GB, 4'd0);
      end
      6'd21: begin
        w.mul = mul_op(A_ALPHA, 4'd0, B_DLT, 2'd0);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_RND);
        w.wb  = wb(WB_GB, 4'd1);
      end
      6'd22: begin
        w.mul = mul_op(A_ALPHA, 4'd0, B_DLT, 2'd1);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_FILT);
        w.wb  = wb(WB_GB, 4'd2);
      end
      6'd23: begin
        w.mul = mul_op(A_ALPHA, 4'd0, B_DLT, 2'd2);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_FILT);
        w.wb  = wb(WB_F, 4'd0);
      end
      6'd24: begin
        w.mul = mul_op(A_M, 4'd0, B_F, 2'd0);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_FILT);
        w.wb  = wb(WB_F, 4'd1);
      end
      6'd25: begin
        w.mul = mul_op(A_M, 4'd1, B_F, 2'd1);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_RND);
        w.wb  = wb(WB_F, 4'd2);
      end
      6'd26: begin
        w.mul = mul_op(A_M, 4'd2, B_F, 2'd2);
        w.acc = acc_add(1'b0, 1'b0);
      end
      6'd27: begin
        w.mul = mul_op(A_M, 4'd3, B_F, 2'd0);
        w.acc = acc_add(1'b0, 1'b0);
      end
      6'd28: begin
        w.mul = mul_op(A_M, 4'd4, B_F, 2'd1);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_RND);
        w.wb  = wb(WB_E, 4'd0);
      end
      6'd29: begin
        w.mul = mul_op(A_M, 4'd5, B_F, 2'd2);
        w.acc = acc_add(1'b0, 1'b0);
      end
      6'd30: begin
        w.mul = mul_op(A_M, 4'd6, B_F, 2'd0);
        w.acc = acc_add(1'b0, 1'b0);
      end
      6'd31: begin
        w.mul = mul_op(A_M, 4'd7, B_F, 2'd1);
        w.acc = acc_ld(1'b0, 1'b0, BIAS_RND);
        w.wb  = wb(WB_E, 4'd1);
      end
      6'd32: begin
        w.mul = mul_op(A_M, 4'd8, B_F, 2'd2);
        w.acc = acc_add(1'b0, 1'b0);
      end
      6'd33: begin
        w.acc = acc_add(1'b0, 1'b0);
      end
      6'd34: begin
        w.wb = wb(WB_E, 4'd2);
      end
      6'd35: begin
        w.sq = '{cond: COND_OUT_FREE, hold: 1'b1, target: STEP_WAIT, emit: 1'b1};
      end
      default: begin
        w = CTRL_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[design/grma_if.sv]
interface grma_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

interface grma_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] earth_accel_x;
  logic signed [15:0] earth_accel_y;
  logic signed [15:0] earth_accel_z;
  logic signed [15:0] body_accel_x;
  logic signed [15:0] body_accel_y;
  logic signed [15:0] body_accel_z;

  modport source (output valid, earth_accel_x, earth_accel_y, earth_accel_z,
                  body_accel_x, body_accel_y, body_accel_z, input ready);
  modport sink (input valid, earth_accel_x, earth_accel_y, earth_accel_z,
                body_accel_x, body_accel_y, body_accel_z, output ready);
endinterface

interface grma_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [grma_pkg::CFG_IDX_W-1:0]  index;
  logic [grma_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/grma_seq.sv]
module grma_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grma_pkg::seq_stat_t   stat_i,
  output grma_pkg::ctrl_t       ctrl_o
);

  logic [grma_pkg::UPC_W-1:0] upc_q, upc_d;
  grma_pkg::ctrl_t            word;
  logic                       taken;

  always_comb begin
    word = grma_pkg::ucode(upc_q);
    unique case (word.sq.cond)
      grma_pkg::COND_NEVER:    taken = 1'b0;
      grma_pkg::COND_IN_FULL:  taken = stat_i.in_full;
      grma_pkg::COND_OUT_FREE: taken = stat_i.out_free;
      default:                 taken = 1'b0;
    endcase

    if (taken) begin
      upc_d = word.sq.target;
    end else if (word.sq.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + grma_pkg::UPC_W'(1);
    end

    // The emit of a conditional step only happens when its jump is taken.
    ctrl_o         = word;
    ctrl_o.sq.emit = word.sq.emit & taken;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= grma_pkg::STEP_WAIT;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[design/grma_dp.sv]
module grma_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  grma_pkg::ctrl_t   ctrl_i,
  input  grma_pkg::item_t   item_i,
  input  grma_pkg::cfg_t    cfg_i,
  output grma_pkg::result_t res_o
);

  logic signed [grma_pkg::A_W-1:0]   a_op;
  logic signed [grma_pkg::B_W-1:0]   b_op;
  logic signed [grma_pkg::B_W-1:0]   dlt;
  logic signed [grma_pkg::P_W-1:0]   prod_d, prod_q;
  logic signed [15:0]                fsel_q;
  logic signed [grma_pkg::ACC_W-1:0] acc_q, acc_d;
  logic signed [grma_pkg::ACC_W-1:0] p_ext, p_sh, addend, bias_val, base;
  logic signed [grma_pkg::GB_W-1:0]  gb;
  logic signed [grma_pkg::GB_W:0]    diff_wide;
  logic signed [15:0]                accel_sel;
  logic signed [15:0]                diff_new, f_new, e_new;

  logic signed [grma_pkg::A_W-1:0]   m_q [9];
  logic signed [15:0]                diff_q [3];
  logic signed [15:0]                f_q [3];
  logic signed [15:0]                e_q [3];

  function automatic logic signed [15:0] q_pick(input grma_pkg::item_t it,
                                                input logic [1:0] idx);
    logic signed [15:0] r;
    unique case (idx)
      2'd0: r = it.quat_w;
      2'd1: r = it.quat_x;
      2'd2: r = it.quat_y;
      2'd3: r = it.quat_z;
      default: r = it.quat_w;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] a_pick(input grma_pkg::item_t it,
                                                input logic [1:0] idx);
    logic signed [15:0] r;
    unique case (idx)
      2'd0: r = it.accel_x;
      2'd1: r = it.accel_y;
      default: r = it.accel_z;
    endcase
    return r;
  endfunction

  // Operand selection and the shared multiplier.
  assign dlt = grma_pkg::B_W'(diff_q[ctrl_i.mul.b_idx]) -
               grma_pkg::B_W'(f_q[ctrl_i.mul.b_idx]);

  always_comb begin
    unique case (ctrl_i.mul.a_sel)
      grma_pkg::A_Q:     a_op = grma_pkg::A_W'(q_pick(item_i, ctrl_i.mul.a_idx[1:0]));
      grma_pkg::A_M:     a_op = m_q[ctrl_i.mul.a_idx];
      grma_pkg::A_ALPHA: a_op = grma_pkg::A_W'(cfg_i.alpha);
      default:           a_op = '0;
    endcase
    unique case (ctrl_i.mul.b_sel)
      grma_pkg::B_Q:   b_op = grma_pkg::B_W'(q_pick(item_i, ctrl_i.mul.b_idx));
      grma_pkg::B_G:   b_op = grma_pkg::B_W'(cfg_i.gravity);
      grma_pkg::B_DLT: b_op = dlt;
      grma_pkg::B_F:   b_op = grma_pkg::B_W'(f_q[ctrl_i.mul.b_idx]);
      default:         b_op = '0;
    endcase
  end

  assign prod_d = a_op * b_op;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    fsel_q <= f_q[ctrl_i.mul.b_idx];
  end

  // Accumulator. The filter bias folds the previous state and the rounding
  // half into one load: prev * 2^16 + 2^15.
  always_comb begin
    p_ext  = grma_pkg::ACC_W'(prod_q);
    p_sh   = ctrl_i.acc.dbl ? (p_ext <<< 1) : p_ext;
    addend = ctrl_i.acc.neg ? -p_sh : p_sh;
    unique case (ctrl_i.acc.bias)
      grma_pkg::BIAS_ZERO: bias_val = '0;
      grma_pkg::BIAS_ONE:  bias_val = grma_pkg::ACC_W'(1) <<< grma_pkg::FRAC_M;
      grma_pkg::BIAS_RND:  bias_val = grma_pkg::ACC_W'(1) <<< (grma_pkg::FRAC_M - 1);
      grma_pkg::BIAS_FILT: bias_val = (grma_pkg::ACC_W'(fsel_q) <<< grma_pkg::FRAC_F) |
                                      (grma_pkg::ACC_W'(1) <<< (grma_pkg::FRAC_F - 1));
      default:             bias_val = '0;
    endcase
    base  = (ctrl_i.acc.op == grma_pkg::ACC_LOAD) ? bias_val : acc_q;
    acc_d = base + addend;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc.op != grma_pkg::ACC_NOP) begin
      acc_q <= acc_d;
    end
  end

  // Write-back results; taking the upper bits is the arithmetic shift.
  always_comb begin
    gb        = $signed(acc_q[grma_pkg::ACC_W-1:grma_pkg::FRAC_M]);
    accel_sel = a_pick(item_i, ctrl_i.wb.idx[1:0]);
    diff_wide = (grma_pkg::GB_W + 1)'(accel_sel) - (grma_pkg::GB_W + 1)'(gb);
    diff_new  = grma_pkg::sat16(grma_pkg::SAT_W'(diff_wide));
    f_new     = grma_pkg::sat16($signed(acc_q[grma_pkg::ACC_W-1:grma_pkg::FRAC_F]));
    e_new     = grma_pkg::sat16(grma_pkg::SAT_W'(gb));
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.wb.op)
      grma_pkg::WB_M:  m_q[ctrl_i.wb.idx]         <= acc_q[grma_pkg::A_W-1:0];
      grma_pkg::WB_GB: diff_q[ctrl_i.wb.idx[1:0]] <= diff_new;
      grma_pkg::WB_E:  e_q[ctrl_i.wb.idx[1:0]]    <= e_new;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q[0] <= '0;
      f_q[1] <= '0;
      f_q[2] <= '0;
    end else if (ctrl_i.wb.op == grma_pkg::WB_F) begin
      f_q[ctrl_i.wb.idx[1:0]] <= f_new;
    end
  end

  assign res_o = '{earth_accel_x: e_q[0], earth_accel_y: e_q[1], earth_accel_z: e_q[2],
                   body_accel_x: f_q[0], body_accel_y: f_q[1], body_accel_z: f_q[2]};

endmodule

[design/gravity_removed_motion_accel.sv]
// A result is offered once its item has run through the microprogram, if the output is free.
// An item is held until its result is emitted, so the next item waits while the 36-step
// microprogram runs all 33 products through one shared 34x17 multiplier.
// A result waiting at the output holds the sequencer in its last step until it transfers.
// Reset (asynchronous, active low) clears the sequencer, the handshake flags and the filter
// state, and restores gravity to 1256 and the filter weight to 6898.
module gravity_removed_motion_accel (
  input  logic              clk_i,
  input  logic              rst_ni,
  grma_in_if.sink           in_i,
  grma_out_if.source        out_o,
  grma_cfg_if.sink          cfg_i
);

  grma_pkg::item_t     in_q;
  logic                in_full_q;
  grma_pkg::result_t   out_q;
  grma_pkg::result_t   res;
  logic                out_valid_q;
  grma_pkg::cfg_t      cfg_q;
  grma_pkg::ctrl_t     ctrl;
  grma_pkg::seq_stat_t stat;
  logic                in_xfer;
  logic                out_xfer;

  assign in_i.ready  = ~in_full_q;
  assign in_xfer     = in_i.valid & ~in_full_q;
  assign out_xfer    = out_valid_q & out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign stat.in_full  = in_full_q;
  assign stat.out_free = ~out_valid_q | out_o.ready;

  grma_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  grma_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      cfg_q.gravity <= grma_pkg::GRAVITY_RESET;
      cfg_q.alpha   <= grma_pkg::ALPHA_RESET;
    end else begin
      // The item is held until its result is emitted.
      if (in_xfer) begin
        in_full_q <= 1'b1;
      end else if (ctrl.sq.emit) begin
        in_full_q <= 1'b0;
      end

      if (ctrl.sq.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid) begin
        if (cfg_i.index == grma_pkg::REG_GRAVITY) begin
          cfg_q.gravity <= cfg_i.data[11:0];
        end else if (cfg_i.index == grma_pkg::REG_ALPHA) begin
          cfg_q.alpha <= cfg_i.data[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= '{quat_w: in_i.quat_w, quat_x: in_i.quat_x, quat_y: in_i.quat_y,
                quat_z: in_i.quat_z, accel_x: in_i.accel_x, accel_y: in_i.accel_y,
                accel_z: in_i.accel_z};
    end
    if (ctrl.sq.emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.earth_accel_x = out_q.earth_accel_x;
  assign out_o.earth_accel_y = out_q.earth_accel_y;
  assign out_o.earth_accel_z = out_q.earth_accel_z;
  assign out_o.body_accel_x  = out_q.body_accel_x;
  assign out_o.body_accel_y  = out_q.body_accel_y;
  assign out_o.body_accel_z  = out_q.body_accel_z;

endmodule
